>>> sv/ibfc_pkg.sv
// Package for the indicator blink/fade colour core: widths, codes, shared types
// and the elaboration-time brightness ROM builder.
// No dependencies.
`default_nettype none
package ibfc_pkg;

    // Fixed field widths and block constants
    localparam int SINE_STEPS = 256;
    localparam int LEVEL_BITS = 8;
    localparam int NUM_IND    = 3;
    localparam int TIME_W     = 32;
    localparam int PER_W      = 16;
    localparam int COLOUR_W   = 24;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Derived widths
    localparam int IDX_W = $clog2(SINE_STEPS);
    localparam int LVL_W = LEVEL_BITS + 1;
    localparam int DVD_W = PER_W + IDX_W;
    localparam int CNT_W = $clog2(((TIME_W > DVD_W) ? TIME_W : DVD_W) + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODES        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOUR_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ONE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TWO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_THREE = 3'd6;

    // Indicator modes; also used as the per-item class
    typedef logic [MODE_W-1:0] t_cls;
    localparam t_cls CLS_OFF   = 2'd0;
    localparam t_cls CLS_SOLID = 2'd1;
    localparam t_cls CLS_BLINK = 2'd2;
    localparam t_cls CLS_FADE  = 2'd3;

    typedef struct packed {
        logic [MODE_W*NUM_IND-1:0]           modes;
        logic [NUM_IND-1:0][COLOUR_W-1:0]    colour;
        logic [NUM_IND-1:0][PER_W-1:0]       period;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]       time_ms;
        t_cls [NUM_IND-1:0]      cls;
    } t_item;

    typedef struct packed {
        logic [NUM_IND-1:0]                  drive;
        logic [NUM_IND-1:0][COLOUR_W-1:0]    shade;
    } t_result;

    typedef logic [LVL_W-1:0] t_level_rom [SINE_STEPS];

    // Brightness per sine step: quarter-wave odd polynomial in Q16, folded
    function automatic t_level_rom build_level_rom();
        t_level_rom      rom;
        longint unsigned q;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned frac;
        longint unsigned r2;
        longint unsigned p;
        longint unsigned sum;
        longint unsigned lvl;
        int              i;
        for (i = 0; i < SINE_STEPS; i++) begin
            q    = longint'(i) * 4;
            quad = (q / SINE_STEPS) & 3;
            rem  = q % SINE_STEPS;
            if (quad[0]) rem = SINE_STEPS - rem;
            frac = (rem << 16) / SINE_STEPS;
            r2   = (frac * frac) >> 16;
            p    = 11;
            p    = 307 - ((p * r2) >> 16);
            p    = 5223 - ((p * r2) >> 16);
            p    = 42334 - ((p * r2) >> 16);
            p    = 102944 - ((p * r2) >> 16);
            p    = (p * frac) >> 16;
            if (p > 65536) p = 65536;
            sum  = quad[1] ? (65536 - p) : (65536 + p);
            lvl  = ((sum << LEVEL_BITS) + 65536) >> 17;
            rom[i] = LVL_W'(lvl);
        end
        return rom;
    endfunction

endpackage
`default_nettype wire

>>> sv/ibfc_front.sv
// Front end: accepts time transactions, classifies each indicator and queues
// the item for the back end. Depends on ibfc_pkg.
`default_nettype none
module ibfc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ibfc_pkg::t_cfg        i_cfg,
    input  wire                   push,
    output logic                  full,
    input  wire  [ibfc_pkg::TIME_W-1:0] i_time_ms,
    output logic                  o_valid,
    output ibfc_pkg::t_item       o_item,
    input  wire                   i_take
);

    ibfc_pkg::t_item r_mem [2];
    logic [1:0]      r_cnt;
    logic            r_wp;
    logic            r_rp;
    ibfc_pkg::t_item w_item;
    logic            w_wr;
    logic            w_rd;

    // Classify: a zero period turns blink or fade into solid
    always_comb begin
        ibfc_pkg::t_cls m;
        w_item.time_ms = i_time_ms;
        for (int k = 0; k < ibfc_pkg::NUM_IND; k++) begin
            m = i_cfg.modes[k*ibfc_pkg::MODE_W +: ibfc_pkg::MODE_W];
            if ((m == ibfc_pkg::CLS_BLINK || m == ibfc_pkg::CLS_FADE) &&
                i_cfg.period[k] == '0) begin
                w_item.cls[k] = ibfc_pkg::CLS_SOLID;
            end else begin
                w_item.cls[k] = m;
            end
        end
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_wr    = push & ~full;
    assign w_rd    = i_take & o_valid;
    assign o_item  = r_mem[r_rp];

    // Two-entry queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= w_item;
    end

endmodule
`default_nettype wire

>>> sv/ibfc_back.sv
// Back end: bit-serial time modulo, sine index divider, ROM lookup and
// channel scaling for three indicator lanes. Depends on ibfc_pkg.
`default_nettype none
module ibfc_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ibfc_pkg::t_cfg        i_cfg,
    input  wire                   i_valid,
    input  ibfc_pkg::t_item       i_item,
    output logic                  o_take,
    output logic                  o_push,
    output ibfc_pkg::t_result     o_result,
    input  wire                   i_full
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_LVL  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;

    localparam int NI  = ibfc_pkg::NUM_IND;
    localparam int PW  = ibfc_pkg::PER_W;
    localparam int IW  = ibfc_pkg::IDX_W;
    localparam int DW  = ibfc_pkg::DVD_W;
    localparam int LW  = ibfc_pkg::LVL_W;
    localparam int CW  = ibfc_pkg::CHAN_W;

    localparam ibfc_pkg::t_level_rom LevelRom = ibfc_pkg::build_level_rom();

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [ibfc_pkg::CNT_W-1:0]   r_cnt;
    logic [ibfc_pkg::TIME_W-1:0]  r_time;
    ibfc_pkg::t_cls [NI-1:0]      r_cls;
    logic [PW:0]                  r_m2   [NI];
    logic                         r_on   [NI];
    logic [DW-1:0]                r_dvd  [NI];
    logic [PW-1:0]                r_pr   [NI];
    logic [IW-1:0]                r_quo  [NI];
    logic [LW-1:0]                r_lvl  [NI];

    assign o_take = (r_state == S_IDLE) && i_valid;
    assign o_push = (r_state == S_MUL) && !i_full;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_MOD;
            S_MOD:  if (r_cnt == ibfc_pkg::CNT_W'(ibfc_pkg::TIME_W - 1)) n_state = S_FIX;
            S_FIX:  n_state = S_DIV;
            S_DIV:  if (r_cnt == ibfc_pkg::CNT_W'(DW - 1)) n_state = S_LVL;
            S_LVL:  n_state = S_MUL;
            S_MUL:  if (!i_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MOD || r_state == S_DIV) begin
                r_cnt <= (n_state == r_state) ? r_cnt + 1'b1 : '0;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // Lane datapath: one restoring step per cycle per lane
    always_ff @(posedge i_clk) begin
        logic [PW+1:0] rem_sh;
        logic [PW+1:0] dsr;
        logic [PW:0]   p17;
        logic [PW:0]   dif;
        logic [PW-1:0] m1;
        logic [PW:0]   pr_sh;
        logic          ge;
        unique case (r_state)
            S_IDLE: begin
                r_time <= i_item.time_ms;
                r_cls  <= i_item.cls;
                for (int k = 0; k < NI; k++) r_m2[k] <= '0;
            end
            S_MOD: begin
                r_time <= {r_time[ibfc_pkg::TIME_W-2:0], 1'b0};
                for (int k = 0; k < NI; k++) begin
                    rem_sh = {r_m2[k], r_time[ibfc_pkg::TIME_W-1]};
                    dsr    = {1'b0, i_cfg.period[k], 1'b0};
                    if (rem_sh >= dsr) rem_sh = rem_sh - dsr;
                    r_m2[k] <= rem_sh[PW:0];
                end
            end
            S_FIX: begin
                for (int k = 0; k < NI; k++) begin
                    p17 = {1'b0, i_cfg.period[k]};
                    dif = r_m2[k] - p17;
                    m1  = (r_m2[k] < p17) ? r_m2[k][PW-1:0] : dif[PW-1:0];
                    r_on[k]  <= (r_m2[k] < p17);
                    r_dvd[k] <= DW'({16'b0, m1} * 32'(ibfc_pkg::SINE_STEPS));
                    r_pr[k]  <= '0;
                    r_quo[k] <= '0;
                end
            end
            S_DIV: begin
                for (int k = 0; k < NI; k++) begin
                    pr_sh = {r_pr[k], r_dvd[k][DW-1]};
                    ge    = (pr_sh >= {1'b0, i_cfg.period[k]});
                    if (ge) pr_sh = pr_sh - {1'b0, i_cfg.period[k]};
                    r_pr[k]  <= pr_sh[PW-1:0];
                    r_quo[k] <= {r_quo[k][IW-2:0], ge};
                    r_dvd[k] <= {r_dvd[k][DW-2:0], 1'b0};
                end
            end
            S_LVL: begin
                for (int k = 0; k < NI; k++) r_lvl[k] <= LevelRom[r_quo[k]];
            end
            default: begin
            end
        endcase
    end

    // Result: per-class colour, fade scales each channel by the level
    always_comb begin
        logic [ibfc_pkg::COLOUR_W-1:0] col;
        logic [ibfc_pkg::COLOUR_W-1:0] fad;
        logic [CW+LW-1:0]              prod;
        logic [CW+LW-1:0]              sc;
        for (int k = 0; k < NI; k++) begin
            col = i_cfg.colour[k];
            for (int c = 0; c < ibfc_pkg::NUM_CHAN; c++) begin
                prod = {{LW{1'b0}}, col[c*CW +: CW]} * {{CW{1'b0}}, r_lvl[k]};
                sc   = prod >> ibfc_pkg::LEVEL_BITS;
                fad[c*CW +: CW] = (sc > (CW+LW)'({CW{1'b1}})) ? {CW{1'b1}} : sc[CW-1:0];
            end
            o_result.drive[k] = (r_cls[k] != ibfc_pkg::CLS_OFF);
            case (r_cls[k])
                ibfc_pkg::CLS_OFF:   o_result.shade[k] = '0;
                ibfc_pkg::CLS_BLINK: o_result.shade[k] = r_on[k] ? col : '0;
                ibfc_pkg::CLS_FADE:  o_result.shade[k] = fad;
                default:             o_result.shade[k] = col;
            endcase
        end
    end

    // Checks
    a_push_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_state == S_MUL))
        else $error("result pushed outside scaling step");

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_state == S_IDLE))
        else $error("back end did not return to idle after push");

    for (genvar g = 0; g < NI; g++) begin : g_chk
        a_mod_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_FIX && r_cls[g] == ibfc_pkg::CLS_FADE) |->
            (r_m2[g] < {i_cfg.period[g], 1'b0}))
            else $error("time modulo out of range");

        a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_LVL && r_cls[g] == ibfc_pkg::CLS_FADE) |->
            (r_pr[g] < i_cfg.period[g]))
            else $error("index divider remainder out of range");
    end

endmodule
`default_nettype wire

>>> sv/ibfc_outq.sv
// Result queue: two entries between the back end and the result ports.
// Depends on ibfc_pkg.
`default_nettype none
module ibfc_outq (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  ibfc_pkg::t_result     i_data,
    output logic                  o_full,
    output logic                  o_empty,
    input  wire                   i_pop,
    output ibfc_pkg::t_result     o_head
);

    ibfc_pkg::t_result r_mem [2];
    logic [1:0]        r_cnt;
    logic              r_wp;
    logic              r_rp;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_head  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

>>> sv/indicator_blink_fade_colour_core.sv
// Top level of the indicator blink/fade colour core: configuration registers,
// front end, back end and result queue. Depends on ibfc_pkg and the ibfc modules.
`default_nettype none
// Each time transaction gives one result with the drive flag and colour of
// three indicators (off, solid, blink, fade). The back end takes an item in its
// idle state and takes no other until it has pushed the result. It runs a
// bit-serial time modulo (twice the period), one fixup, a bit-serial sine index
// division, a ROM lookup and a scaling step that waits while the result queue
// is full; all three indicators run in parallel lanes. Two-entry queues on
// both sides let input and output stall independently. The user must write
// configuration only while no transaction is in flight; the block does not enforce it.
module indicator_blink_fade_colour_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [ibfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [ibfc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 push,
    output logic                                full,
    input  wire  [ibfc_pkg::TIME_W-1:0]         i_time_ms,
    output logic                                empty,
    input  wire                                 pop,
    output logic                                o_drive_one,
    output logic [ibfc_pkg::COLOUR_W-1:0]       o_shade_one,
    output logic                                o_drive_two,
    output logic [ibfc_pkg::COLOUR_W-1:0]       o_shade_two,
    output logic                                o_drive_three,
    output logic [ibfc_pkg::COLOUR_W-1:0]       o_shade_three
);

    ibfc_pkg::t_cfg    r_cfg;
    ibfc_pkg::t_item   w_item;
    ibfc_pkg::t_result w_res;
    ibfc_pkg::t_result w_head;
    logic              w_valid;
    logic              w_take;
    logic              w_push;
    logic              w_qfull;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ibfc_pkg::REG_MODES:        r_cfg.modes     <= i_cfg_data[5:0];
                ibfc_pkg::REG_COLOUR_ONE:   r_cfg.colour[0] <= i_cfg_data;
                ibfc_pkg::REG_COLOUR_TWO:   r_cfg.colour[1] <= i_cfg_data;
                ibfc_pkg::REG_COLOUR_THREE: r_cfg.colour[2] <= i_cfg_data;
                ibfc_pkg::REG_PERIOD_ONE:   r_cfg.period[0] <= i_cfg_data[15:0];
                ibfc_pkg::REG_PERIOD_TWO:   r_cfg.period[1] <= i_cfg_data[15:0];
                ibfc_pkg::REG_PERIOD_THREE: r_cfg.period[2] <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    ibfc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .push      (push),
        .full      (full),
        .i_time_ms (i_time_ms),
        .o_valid   (w_valid),
        .o_item    (w_item),
        .i_take    (w_take)
    );

    ibfc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_valid),
        .i_item   (w_item),
        .o_take   (w_take),
        .o_push   (w_push),
        .o_result (w_res),
        .i_full   (w_qfull)
    );

    ibfc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_qfull),
        .o_empty (empty),
        .i_pop   (pop),
        .o_head  (w_head)
    );

    assign o_drive_one   = w_head.drive[0];
    assign o_shade_one   = w_head.shade[0];
    assign o_drive_two   = w_head.drive[1];
    assign o_shade_two   = w_head.shade[1];
    assign o_drive_three = w_head.drive[2];
    assign o_shade_three = w_head.shade[2];

endmodule
`default_nettype wire
